// ----- sv/swrl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swrl_pkg;

   // Stream and register port widths
   localparam int USER_ID_W   = 8;
   localparam int REQ_TIME_W  = 32;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_REQ_W   = 4;
   localparam int WINDOW_W    = 16;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_REQUESTS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

   // Register reset values
   localparam logic [MAX_REQ_W-1:0] MAX_REQUESTS_RESET  = 4'd1;
   localparam logic [WINDOW_W-1:0]  WINDOW_LENGTH_RESET = 16'd60;

   typedef struct packed {
      logic [MAX_REQ_W-1:0] max_requests;
      logic [WINDOW_W-1:0]  window_length;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_COMPARE,
      BK_SCAN,
      BK_UPDATE
   } back_state_type;

endpackage

`default_nettype wire

// ----- sv/swrl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swrl_front #(
   parameter int NUM_USERS = 256,
   parameter int TIME_BITS = 32
) (
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [swrl_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                          clearing,
   input  wire logic                          q_full,
   output logic                               push,
   output logic [((NUM_USERS > 1) ? $clog2(NUM_USERS) : 1)-1:0] push_user,
   output logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0]        push_time
);
   import swrl_pkg::*;

   localparam int UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
   localparam int TW = (TIME_BITS < REQ_TIME_W) ? TIME_BITS : REQ_TIME_W;
   localparam int NUM_IDS = 2 ** USER_ID_W;

   typedef logic [UW-1:0] user_map_type [NUM_IDS];

   // Fold every possible id onto the user range
   function automatic user_map_type build_user_map();
      user_map_type m;
      for (int i = 0; i < NUM_IDS; i++) begin
         m[i] = UW'(i % NUM_USERS);
      end
      return m;
   endfunction

   localparam user_map_type USER_MAP = build_user_map();

   logic [USER_ID_W-1:0]  user_id;
   logic [REQ_TIME_W-1:0] request_time;

   assign user_id      = req_tdata[USER_ID_W-1:0];
   assign request_time = req_tdata[USER_ID_W +: REQ_TIME_W];

   // Take a request when the queue has room and the clearing pass is done
   assign req_tready = !q_full && !clearing;
   assign push       = req_tvalid && req_tready;

   // Map the user and trim the timestamp to the stored width
   assign push_user = USER_MAP[user_id];
   assign push_time = request_time[TW-1:0];

endmodule

`default_nettype wire

// ----- sv/swrl_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swrl_queue #(
   parameter int DATA_W = 40
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   empty
);
   import swrl_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff,  count_in;

   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming request
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/swrl_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swrl_back #(
   parameter int NUM_USERS = 256,
   parameter int MAX_K     = 8,
   parameter int TIME_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire swrl_pkg::cfg_type cfg,
   input  wire logic              q_empty,
   input  wire logic [((NUM_USERS > 1) ? $clog2(NUM_USERS) : 1)-1:0] q_user,
   input  wire logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0]        q_time,
   output logic                   pop,
   output logic                   clearing,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic                   out_allowed
);
   import swrl_pkg::*;

   localparam int UW   = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
   localparam int TW   = (TIME_BITS < REQ_TIME_W) ? TIME_BITS : REQ_TIME_W;
   localparam int HW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int OW   = $clog2(MAX_K + 1);
   localparam int SW   = OW + 1;
   localparam int EW   = ((TW > WINDOW_W) ? TW : WINDOW_W) + 1;
   localparam int CMPW = (OW > MAX_REQ_W) ? OW : MAX_REQ_W;
   localparam int MW   = HW + OW;

   // Per-user ring of allowed times, and per-user head and occupancy
   logic [MAX_K*TW-1:0] time_mem [NUM_USERS];
   logic [MW-1:0]       meta_mem [NUM_USERS];

   logic [MAX_K*TW-1:0] time_rd_ff;
   logic [MW-1:0]       meta_rd_ff;

   back_state_type state_ff, state_in;
   logic [UW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [UW-1:0]    user_ff, user_in;
   logic [TW-1:0]    now_ff, now_in;
   logic [MAX_K-1:0] evict_ff, evict_in;
   logic [HW-1:0]    head_ff, head_in;
   logic [OW-1:0]    occ_ff, occ_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_allowed_ff, out_allowed_in;

   logic                rd_en;
   logic                meta_we;
   logic [UW-1:0]       meta_waddr;
   logic [MW-1:0]       meta_wdata;
   logic                time_we;
   logic [MAX_K*TW-1:0] time_wdata;

   logic [HW-1:0]   head_rd;
   logic [OW-1:0]   occ_rd;
   logic [OW-1:0]   evict_cnt;
   logic [HW-1:0]   head_next;
   logic [CMPW-1:0] limit;
   logic            allow;
   logic [HW-1:0]   wr_slot;

   assign head_rd = meta_rd_ff[MW-1:OW];
   assign occ_rd  = meta_rd_ff[OW-1:0];

   // Mark each stored time that has left the window
   always_comb begin
      logic [EW-1:0] sum;
      evict_in = evict_ff;
      for (int i = 0; i < MAX_K; i++) begin
         sum = EW'(time_rd_ff[i*TW +: TW]) + EW'(cfg.window_length);
         evict_in[i] = (sum <= EW'(now_ff));
      end
   end

   // Count expired times from the oldest end, stopping at the first live one
   always_comb begin
      logic          run;
      logic [HW:0]   idx_sum;
      logic [HW-1:0] idx;
      logic [SW-1:0] head_sum;
      run       = 1'b1;
      evict_cnt = '0;
      for (int j = 0; j < MAX_K; j++) begin
         idx_sum = (HW+1)'(head_rd) + (HW+1)'(j);
         idx     = (idx_sum >= (HW+1)'(MAX_K)) ? HW'(idx_sum - (HW+1)'(MAX_K))
                                                : idx_sum[HW-1:0];
         if (run && (OW'(j) < occ_rd) && evict_ff[idx]) begin
            evict_cnt = evict_cnt + 1'b1;
         end else begin
            run = 1'b0;
         end
      end
      head_sum  = SW'(head_rd) + SW'(evict_cnt);
      head_next = (head_sum >= SW'(MAX_K)) ? HW'(head_sum - SW'(MAX_K))
                                           : head_sum[HW-1:0];
   end

   // Decide against the limit and pick the slot for the new time
   always_comb begin
      logic [SW-1:0] slot_sum;
      limit    = (CMPW'(cfg.max_requests) > CMPW'(MAX_K)) ? CMPW'(MAX_K)
                                                         : CMPW'(cfg.max_requests);
      allow    = (CMPW'(occ_ff) < limit);
      slot_sum = SW'(head_ff) + SW'(occ_ff);
      wr_slot  = (slot_sum >= SW'(MAX_K)) ? HW'(slot_sum - SW'(MAX_K))
                                          : slot_sum[HW-1:0];
      time_wdata = time_rd_ff;
      for (int i = 0; i < MAX_K; i++) begin
         if (HW'(i) == wr_slot) begin
            time_wdata[i*TW +: TW] = now_ff;
         end
      end
   end

   // Sequence clearing, read, compare, scan and write-back
   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      user_in        = user_ff;
      now_in         = now_ff;
      head_in        = head_ff;
      occ_in         = occ_ff;
      out_valid_in   = out_valid_ff && !out_ready;
      out_allowed_in = out_allowed_ff;
      pop            = 1'b0;
      rd_en          = 1'b0;
      meta_we        = 1'b0;
      meta_waddr     = user_ff;
      meta_wdata     = {head_ff, occ_ff};
      time_we        = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_cnt_ff;
            meta_wdata = '0;
            if (clr_cnt_ff == UW'(NUM_USERS - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               user_in  = q_user;
               now_in   = q_time;
               state_in = BK_COMPARE;
            end
         end
         BK_COMPARE: begin
            state_in = BK_SCAN;
         end
         BK_SCAN: begin
            head_in  = head_next;
            occ_in   = occ_rd - evict_cnt;
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            if (!out_valid_ff || out_ready) begin
               meta_we        = 1'b1;
               meta_wdata     = {head_ff, allow ? occ_ff + 1'b1 : occ_ff};
               time_we        = allow;
               out_valid_in   = 1'b1;
               out_allowed_in = allow;
               state_in       = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the request and the intermediate results
   always_ff @(posedge clock) begin
      user_ff        <= user_in;
      now_ff         <= now_in;
      evict_ff       <= evict_in;
      head_ff        <= head_in;
      occ_ff         <= occ_in;
      out_allowed_ff <= out_allowed_in;
   end

   // Memory ports: registered read, single write each
   always_ff @(posedge clock) begin
      if (rd_en) begin
         time_rd_ff <= time_mem[q_user];
         meta_rd_ff <= meta_mem[q_user];
      end
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      if (time_we) begin
         time_mem[user_ff] <= time_wdata;
      end
   end

   assign clearing    = (state_ff == BK_CLEAR);
   assign out_valid   = out_valid_ff;
   assign out_allowed = out_allowed_ff;

endmodule

`default_nettype wire

// ----- sv/sliding_window_rate_limiter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window-log rate limiter. Each request carries a user id and a
// timestamp (non-decreasing); the block keeps, per user, up to MAX_K times of
// recently allowed requests, drops those with time + window_length <= request
// time (oldest first, stopping at the first one still in the window), and
// allows the request if fewer than max_requests (capped at MAX_K) times
// remain, storing its time. One result per request, in order. A front stage
// maps the user id (modulo NUM_USERS) and queues up to two requests; the back
// engine takes one request at a time through memory read, window compare,
// eviction scan and write-back, and pops the next only after that write-back,
// which waits while the previous result is unaccepted. After reset a clearing
// pass zeroes the per-user occupancy; req_tready stays low during it. Register
// writes are taken at any time but must only be issued while the block is idle.

module sliding_window_rate_limiter #(
   parameter int NUM_USERS = 256,
   parameter int MAX_K     = 8,
   parameter int TIME_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: user_id [7:0], request_time [39:8]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [swrl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: allowed [0], zero [7:1]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [swrl_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [swrl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [swrl_pkg::CSR_DATA_W-1:0]   csr_data
);
   import swrl_pkg::*;

   localparam int UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
   localparam int TW = (TIME_BITS < REQ_TIME_W) ? TIME_BITS : REQ_TIME_W;
   localparam int QW = UW + TW;

   cfg_type cfg_ff, cfg_in;

   logic          q_push, q_full, q_pop, q_empty;
   logic [UW-1:0] push_user;
   logic [TW-1:0] push_time;
   logic [QW-1:0] q_pop_data;
   logic          back_clearing;
   logic          rsp_allowed;

   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_MAX_REQUESTS:  cfg_in.max_requests  = csr_data[MAX_REQ_W-1:0];
            REG_WINDOW_LENGTH: cfg_in.window_length = csr_data[WINDOW_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_requests  <= MAX_REQUESTS_RESET;
         cfg_ff.window_length <= WINDOW_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swrl_front #(
      .NUM_USERS (NUM_USERS),
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .clearing   (back_clearing),
      .q_full     (q_full),
      .push       (q_push),
      .push_user  (push_user),
      .push_time  (push_time)
   );

   swrl_queue #(
      .DATA_W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_time, push_user}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   swrl_back #(
      .NUM_USERS (NUM_USERS),
      .MAX_K     (MAX_K),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .q_user      (q_pop_data[UW-1:0]),
      .q_time      (q_pop_data[QW-1:UW]),
      .pop         (q_pop),
      .clearing    (back_clearing),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_allowed (rsp_allowed)
   );

   assign rsp_tdata = {{(RSP_DATA_W-1){1'b0}}, rsp_allowed};

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push) else $error("request pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("request popped from an empty queue");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      back_clearing |-> !req_tready) else $error("request taken during clearing");

   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      back_clearing |-> !rsp_tvalid) else $error("result shown during clearing");
`endif

endmodule

`default_nettype wire

// ----- dv/sliding_window_rate_limiter_tb.sv -----
`timescale 1ns / 1ps

module sliding_window_rate_limiter_tb;
   import swrl_pkg::*;

   localparam int NUM_USERS    = 256;
   localparam int RING_DEPTH   = 8;
   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_LIMIT  = 4000;
   localparam int LIST_DEPTH   = 2048;

   // Request payload as it sits in req_tdata: user_id low, request_time high
   typedef struct packed {
      logic [REQ_TIME_W-1:0] request_time;
      logic [USER_ID_W-1:0]  user_id;
   } request_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   sliding_window_rate_limiter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Shadow of the per-user log of allowed request times
   logic [REQ_TIME_W-1:0] allowed_log [NUM_USERS][RING_DEPTH];
   logic [3:0]            log_count [NUM_USERS];
   logic [2:0]            log_head [NUM_USERS];
   logic [MAX_REQ_W-1:0]  max_req_cfg = MAX_REQUESTS_RESET;
   logic [WINDOW_W-1:0]   window_cfg = WINDOW_LENGTH_RESET;

   // Pending requests and expected answers, as lists with read and write counts
   request_type pending_req [LIST_DEPTH];
   int          pend_wr = 0;
   int          pend_rd = 0;
   logic        exp_allowed [LIST_DEPTH];
   int          exp_wr = 0;
   int          exp_rd = 0;

   bit          running = 1'b0;
   bit          req_taken = 1'b0;
   int unsigned tx_idle_pct = 30;
   int unsigned rx_idle_pct = 75;
   int          error_count = 0;
   int          stall_cycles = 0;
   int          n_requests = 0;
   int          n_allowed = 0;
   int          n_denied = 0;
   int          n_csr_writes = 0;
   longint unsigned stamp_cursor = 0;

   // Drop expired times from the oldest end, then admit if below the limit
   function automatic logic decide_request(input logic [USER_ID_W-1:0] uid,
                                           input logic [REQ_TIME_W-1:0] now_t);
      logic [3:0]            occ;
      logic [2:0]            head;
      logic [2:0]            slot;
      logic [3:0]            cap;
      logic [REQ_TIME_W-1:0] cutoff;
      occ  = log_count[uid];
      head = log_head[uid];
      cap  = (max_req_cfg > RING_DEPTH) ? 4'(RING_DEPTH) : max_req_cfg;
      if (now_t >= window_cfg) begin
         cutoff = now_t - window_cfg;
         while (occ != 0 && allowed_log[uid][head] <= cutoff) begin
            head = head + 3'd1;
            occ  = occ - 4'd1;
         end
      end
      decide_request = 1'b0;
      if (occ < cap) begin
         slot = head + occ[2:0];
         allowed_log[uid][slot] = now_t;
         occ = occ + 4'd1;
         decide_request = 1'b1;
      end
      log_count[uid] = occ;
      log_head[uid]  = head;
   endfunction

   // Request driver and response backpressure
   always @(negedge clock) begin
      if (running) begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         if (!req_tvalid || req_taken) begin
            if (pend_rd != pend_wr && $urandom_range(0, 99) >= tx_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_req[pend_rd % LIST_DEPTH];
               pend_rd++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         req_taken = 1'b0;
      end
   end

   // Predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      request_type req;
      logic        want;
      bit          progress;
      progress = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         req = request_type'(req_tdata);
         exp_allowed[exp_wr % LIST_DEPTH] = decide_request(req.user_id, req.request_time);
         exp_wr++;
         req_taken = 1'b1;
         progress  = 1'b1;
         n_requests++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         progress = 1'b1;
         if (exp_rd == exp_wr) begin
            $error("allowed: no request outstanding, actual %0b", rsp_tdata[0]);
            error_count++;
         end else begin
            want = exp_allowed[exp_rd % LIST_DEPTH];
            exp_rd++;
            if (rsp_tdata[0] !== want) begin
               $error("allowed: expected %0b, actual %0b", want, rsp_tdata[0]);
               error_count++;
            end
            if (want) n_allowed++;
            else n_denied++;
         end
      end
      if (!reset && csr_valid && csr_ready) progress = 1'b1;
      // Abort when nothing moves for too long
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake in %0d cycles", STALL_LIMIT);
         $display("sliding_window_rate_limiter: mismatch");
         $finish;
      end
   end

   task automatic push_req(input logic [USER_ID_W-1:0] uid, input logic [REQ_TIME_W-1:0] t);
      request_type r;
      r.user_id      = uid;
      r.request_time = t;
      pending_req[pend_wr % LIST_DEPTH] = r;
      pend_wr++;
   endtask

   // Hold until every request is answered and the back end has settled
   task automatic wait_drained();
      while (pend_rd != pend_wr || req_tvalid || exp_rd != exp_wr)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_MAX_REQUESTS) max_req_cfg = val[MAX_REQ_W-1:0];
      else window_cfg = val;
      n_csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [MAX_REQ_W-1:0] max_v, input logic [WINDOW_W-1:0] win_v);
      wait_drained();
      write_csr(REG_MAX_REQUESTS, CSR_DATA_W'(max_v));
      write_csr(REG_WINDOW_LENGTH, win_v);
   endtask

   // Mostly a few busy users on an advancing clock; some stray users,
   // backward steps and wild timestamps as noise
   task automatic queue_traffic(input int count, input int unsigned step_max,
                                input int unsigned win_v);
      logic [USER_ID_W-1:0]  pool [4];
      logic [USER_ID_W-1:0]  uid;
      logic [REQ_TIME_W-1:0] t;
      int unsigned           back;
      int unsigned           roll;
      foreach (pool[i]) pool[i] = $urandom_range(0, 255);
      if ($urandom_range(0, 1) == 0) begin
         pool[0] = '0;
         pool[1] = '1;
      end
      for (int i = 0; i < count; i++) begin
         stamp_cursor += $urandom_range(0, step_max);
         if (stamp_cursor > 64'hFFFF_FFFF) stamp_cursor = 64'hFFFF_FFFF;
         uid  = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 3)] :
                USER_ID_W'($urandom_range(0, 255));
         t    = REQ_TIME_W'(stamp_cursor);
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            back = $urandom_range(0, win_v);
            t    = (stamp_cursor > back) ? REQ_TIME_W'(stamp_cursor - back) : '0;
         end else if (roll < 7) begin
            t = $urandom;
         end
         push_req(uid, t);
      end
   endtask

   initial begin
      int unsigned wmax;
      for (int u = 0; u < NUM_USERS; u++) begin
         log_count[u] = '0;
         log_head[u]  = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset   <= 1'b0;
      running = 1'b1;

      // Reset limits: early requests evict nothing, exact window edge evicts
      push_req(8'd0, 32'd0);
      push_req(8'd0, 32'd10);
      push_req(8'd0, 32'd59);
      push_req(8'd255, 32'd59);
      push_req(8'd0, 32'd60);
      push_req(8'd255, 32'd118);
      push_req(8'd255, 32'd119);

      // Limit above ring capacity with the widest window
      configure(4'd15, 16'hFFFF);
      repeat (9) push_req(8'd7, 32'd200);
      push_req(8'd7, 32'd65735);

      // Zero limit denies everything
      configure(4'd0, 16'd1);
      push_req(8'd7, 32'd70000);
      push_req(8'd128, 32'd70000);

      // Zero window, then stepping backward in time
      configure(4'd3, 16'd0);
      push_req(8'd3, 32'd80000);
      push_req(8'd3, 32'd80000);
      push_req(8'd3, 32'd90000);
      push_req(8'd3, 32'd85000);
      push_req(8'd3, 32'd84000);
      push_req(8'd3, 32'd83000);

      stamp_cursor = 100000;
      configure(4'd2, 16'd100);
      queue_traffic(190, 60, 100);
      configure(4'd8, 16'd1);
      queue_traffic(190, 1, 1);

      wait_drained();
      tx_idle_pct = 75;
      rx_idle_pct = 30;
      configure(4'd4, 16'hFFFF);
      queue_traffic(190, 20000, 65535);
      wmax = $urandom_range(1, 65535);
      configure(MAX_REQ_W'($urandom_range(0, 15)), WINDOW_W'(wmax));
      queue_traffic(190, wmax / 3 + 1, wmax);

      wait_drained();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      stamp_cursor = 64'h7FFF_0000 + $urandom_range(0, 65535);
      configure(4'd5, 16'd400);
      queue_traffic(190, 150, 400);
      stamp_cursor = 64'hFFFF_0000;
      configure(4'd15, 16'd1000);
      queue_traffic(190, 300, 1000);
      push_req(8'd255, 32'hFFFF_FFFF);

      wait_drained();
      if (exp_wr != exp_rd) begin
         $error("allowed: %0d responses never arrived", exp_wr - exp_rd);
         error_count++;
      end
      $display("covered %0d requests (%0d allowed, %0d denied) over %0d register writes",
               n_requests, n_allowed, n_denied, n_csr_writes);
      $display("limits 0..15, windows 0..65535, stepping back, timestamps up to the top");
      if (error_count == 0) begin
         $display("sliding_window_rate_limiter: match");
      end else begin
         $display("sliding_window_rate_limiter: mismatch");
      end
      $finish;
   end

endmodule

// ----- sliding_window_rate_limiter.f -----
sv/swrl_pkg.sv
sv/swrl_front.sv
sv/swrl_queue.sv
sv/swrl_back.sv
sv/sliding_window_rate_limiter.sv
dv/sliding_window_rate_limiter_tb.sv
